FILE: design/tsf_pkg.sv
// Shared constants, state type and a mask helper for the topological sort feasibility block.
package tsf_pkg;

	localparam int MAX_NODES = 64;
	localparam int NODE_W    = 6;
	localparam int CNT_W     = 7;
	localparam int TDATA_W   = 16;

	localparam logic [CNT_W-1:0]  NODES_MAX = CNT_W'(MAX_NODES);
	localparam logic [CNT_W-1:0]  DEG_MAX   = '1;
	localparam logic [NODE_W-1:0] IDX_LAST  = NODE_W'(MAX_NODES - 1);

	typedef enum logic [9:0] {
		ST_IDLE      = 10'b00_0000_0001,
		ST_LOAD      = 10'b00_0000_0010,
		ST_SCAN      = 10'b00_0000_0100,
		ST_SCAN_END  = 10'b00_0000_1000,
		ST_POP       = 10'b00_0001_0000,
		ST_CUR       = 10'b00_0010_0000,
		ST_ROW       = 10'b00_0100_0000,
		ST_SWEEP     = 10'b00_1000_0000,
		ST_SWEEP_END = 10'b01_0000_0000,
		ST_DONE      = 10'b10_0000_0000
	} tsf_state_t;

	// Mask of the nodes below the given count
	function automatic logic [MAX_NODES-1:0] low_mask(input logic [CNT_W-1:0] n);
		logic [MAX_NODES-1:0] m;
		m = '0;
		for (int k = 0; k < MAX_NODES; k++) begin
			m[k] = (CNT_W'(k) < n);
		end
		return m;
	endfunction

endpackage

FILE: design/topological_sort_feasibility.sv
// Edge loader and Kahn walk with cycle detection over an adjacency memory.
//
// channel   | dir | handshake                      | payload
// ----------+-----+--------------------------------+----------------------------------------
// cfg       | in  | cfg_we                         | cfg_wdata = node_count
// s_axis    | in  | s_axis_tvalid / s_axis_tready  | tdata dep, prereq; tuser edge_valid; tlast
// m_axis    | out | m_axis_tvalid / m_axis_tready  | tdata feasible, ordered_count, bad_edge
//
// An in-range edge needs a memory read, then a write in the load step; other items end in idle.
// After the last item the walk scans every node, then for every node ordered reads its row
// and sweeps its 64 bits over the single in-degree port, then gives the result.
// Reset and each result clear the row and in-degree valid bits at once; no clearing pass.
// A finished result waits in the output register; only the next result stalls on it.
module topological_sort_feasibility
	import tsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_wdata,
	input  logic               s_axis_tvalid,
	output logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,   // [5:0] dependent_node, [11:6] prerequisite_node
	input  logic               s_axis_tuser,   // [0] edge_valid
	input  logic               s_axis_tlast,
	output logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	output logic [TDATA_W-1:0] m_axis_tdata    // [0] feasible, [7:1] ordered_count, [8] bad_edge
);

	tsf_state_t state_q;

	logic [CNT_W-1:0]     node_count_q;
	logic [CNT_W-1:0]     n_eff;
	logic [MAX_NODES-1:0] keep_q;

	logic                 in_accept;
	logic [NODE_W-1:0]    in_dep;
	logic [NODE_W-1:0]    in_pre;
	logic                 in_range;
	logic                 in_store;

	logic [NODE_W-1:0]    dep_q;
	logic [NODE_W-1:0]    pre_q;
	logic                 last_q;

	// Adjacency rows (indexed by prerequisite) and in-degrees
	logic [MAX_NODES-1:0] adj_mem [MAX_NODES];
	logic [MAX_NODES-1:0] adj_rd_q;
	logic [NODE_W-1:0]    adj_raddr;
	logic [NODE_W-1:0]    adj_raddr_q;
	logic [MAX_NODES-1:0] adj_row;
	logic                 adj_we;
	logic [MAX_NODES-1:0] adj_wdata;
	logic [MAX_NODES-1:0] row_vld_q;

	logic [CNT_W-1:0]     deg_mem [MAX_NODES];
	logic [CNT_W-1:0]     deg_rd_q;
	logic [NODE_W-1:0]    deg_raddr;
	logic [NODE_W-1:0]    deg_raddr_q;
	logic [CNT_W-1:0]     deg_val;
	logic                 deg_we;
	logic [NODE_W-1:0]    deg_waddr;
	logic [CNT_W-1:0]     deg_wdata;
	logic [MAX_NODES-1:0] deg_vld_q;

	logic [NODE_W-1:0]    q_mem [MAX_NODES];
	logic [NODE_W-1:0]    q_rd_q;
	logic                 q_we;
	logic [NODE_W-1:0]    q_wdata;
	logic [CNT_W-1:0]     head_q;
	logic [CNT_W-1:0]     tail_q;
	logic [CNT_W-1:0]     removed_q;
	logic                 bad_q;

	logic [NODE_W-1:0]    idx_q;
	logic [NODE_W-1:0]    idx_s1;
	logic                 scan_s1;
	logic                 hit_s1;
	logic [MAX_NODES-1:0] succ_q;

	logic                 edge_new;
	logic                 scan_in_n;
	logic                 scan_bad;
	logic                 out_free;
	logic                 feasible;

	// Effective node count, saturated at the maximum
	assign n_eff = (node_count_q > NODES_MAX) ? NODES_MAX : node_count_q;

	// Input decode
	assign s_axis_tready = (state_q == ST_IDLE);
	assign in_accept     = s_axis_tvalid && s_axis_tready;
	assign in_dep        = s_axis_tdata[NODE_W-1:0];
	assign in_pre        = s_axis_tdata[2*NODE_W-1:NODE_W];
	assign in_range      = ({1'b0, in_dep} < n_eff) && ({1'b0, in_pre} < n_eff);
	assign in_store      = s_axis_tuser && in_range;

	// Read data seen through the valid bits
	assign adj_row = row_vld_q[adj_raddr_q] ? adj_rd_q : '0;
	assign deg_val = deg_vld_q[deg_raddr_q] ? deg_rd_q : '0;

	// Select read addresses for the current step
	always_comb begin
		adj_raddr = idx_q;
		deg_raddr = idx_q;
		case (state_q)
			ST_IDLE: begin
				adj_raddr = in_pre;
				deg_raddr = in_dep;
			end
			ST_CUR: begin
				adj_raddr = q_rd_q;
			end
			default: begin
				adj_raddr = idx_q;
				deg_raddr = idx_q;
			end
		endcase
	end

	// Edge store and in-degree update
	assign edge_new  = (state_q == ST_LOAD) && !adj_row[dep_q];
	assign adj_we    = edge_new;
	assign adj_wdata = adj_row | (MAX_NODES'(1) << dep_q);

	assign deg_we    = edge_new || (hit_s1 && (deg_val != '0));
	assign deg_waddr = edge_new ? dep_q : idx_s1;
	assign deg_wdata = edge_new ? ((deg_val == DEG_MAX) ? DEG_MAX : deg_val + CNT_W'(1))
	                            : deg_val - CNT_W'(1);

	// Scan stage: flag stray bits, queue nodes with no prerequisites; the sweep queues nodes that reach zero
	assign scan_in_n = ({1'b0, idx_s1} < n_eff);
	assign scan_bad  = scan_s1 && (scan_in_n ? |(adj_row & ~keep_q) : |adj_row);

	assign q_we    = (tail_q < NODES_MAX) &&
	                 ((scan_s1 && scan_in_n && (deg_val == '0)) ||
	                  (hit_s1 && (deg_val == CNT_W'(1))));
	assign q_wdata = idx_s1;

	assign out_free = !m_axis_tvalid || m_axis_tready;
	assign feasible = !bad_q && (removed_q == n_eff);

	// Memories
	always_ff @(posedge clk) begin
		adj_rd_q    <= adj_mem[adj_raddr];
		adj_raddr_q <= adj_raddr;
		if (adj_we) begin
			adj_mem[pre_q] <= adj_wdata;
		end
	end

	always_ff @(posedge clk) begin
		deg_rd_q    <= deg_mem[deg_raddr];
		deg_raddr_q <= deg_raddr;
		if (deg_we) begin
			deg_mem[deg_waddr] <= deg_wdata;
		end
	end

	always_ff @(posedge clk) begin
		q_rd_q <= q_mem[head_q[NODE_W-1:0]];
		if (q_we) begin
			q_mem[tail_q[NODE_W-1:0]] <= q_wdata;
		end
	end

	// Configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_count_q <= NODES_MAX;
		end else if (cfg_we) begin
			node_count_q <= cfg_wdata;
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (in_accept) begin
			dep_q  <= in_dep;
			pre_q  <= in_pre;
			last_q <= s_axis_tlast;
			keep_q <= low_mask(n_eff);
		end
		idx_s1 <= idx_q;
		if (state_q == ST_ROW) begin
			succ_q <= adj_row & keep_q;
		end
		if ((state_q == ST_DONE) && out_free) begin
			m_axis_tdata <= TDATA_W'({bad_q, removed_q, feasible});
		end
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			idx_q         <= '0;
			scan_s1       <= 1'b0;
			hit_s1        <= 1'b0;
			head_q        <= '0;
			tail_q        <= '0;
			removed_q     <= '0;
			bad_q         <= 1'b0;
			row_vld_q     <= '0;
			deg_vld_q     <= '0;
			m_axis_tvalid <= 1'b0;
		end else begin
			scan_s1 <= (state_q == ST_SCAN);
			hit_s1  <= (state_q == ST_SWEEP) && succ_q[idx_q];

			if (adj_we) begin
				row_vld_q[pre_q] <= 1'b1;
			end
			if (edge_new) begin
				deg_vld_q[dep_q] <= 1'b1;
			end
			if (q_we) begin
				tail_q <= tail_q + CNT_W'(1);
			end
			if (scan_bad) begin
				bad_q <= 1'b1;
			end
			if (m_axis_tvalid && m_axis_tready && (state_q != ST_DONE)) begin
				m_axis_tvalid <= 1'b0;
			end

			case (state_q)
				ST_IDLE: begin
					idx_q <= '0;
					if (in_accept) begin
						if (s_axis_tuser && !in_range) begin
							bad_q <= 1'b1;
						end
						if (in_store) begin
							state_q <= ST_LOAD;
						end else if (s_axis_tlast) begin
							state_q <= ST_SCAN;
						end
					end
				end
				ST_LOAD: begin
					state_q <= last_q ? ST_SCAN : ST_IDLE;
				end
				ST_SCAN: begin
					idx_q <= idx_q + NODE_W'(1);
					if (idx_q == IDX_LAST) begin
						state_q <= ST_SCAN_END;
					end
				end
				ST_SCAN_END: begin
					state_q <= ST_POP;
				end
				ST_POP: begin
					if (head_q < tail_q) begin
						head_q    <= head_q + CNT_W'(1);
						removed_q <= removed_q + CNT_W'(1);
						state_q   <= ST_CUR;
					end else begin
						state_q <= ST_DONE;
					end
				end
				ST_CUR: begin
					state_q <= ST_ROW;
				end
				ST_ROW: begin
					idx_q   <= '0;
					state_q <= ST_SWEEP;
				end
				ST_SWEEP: begin
					idx_q <= idx_q + NODE_W'(1);
					if (idx_q == IDX_LAST) begin
						state_q <= ST_SWEEP_END;
					end
				end
				ST_SWEEP_END: begin
					state_q <= ST_POP;
				end
				ST_DONE: begin
					// Hold until the output register is free, then clear every store
					if (out_free) begin
						m_axis_tvalid <= 1'b1;
						head_q        <= '0;
						tail_q        <= '0;
						removed_q     <= '0;
						bad_q         <= 1'b0;
						row_vld_q     <= '0;
						deg_vld_q     <= '0;
						state_q       <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Checks
	a_tail_bound: assert property (@(posedge clk) disable iff (!arst_n)
		tail_q <= NODES_MAX)
		else $error("ready queue tail beyond capacity");

	a_head_tail: assert property (@(posedge clk) disable iff (!arst_n)
		head_q <= tail_q)
		else $error("ready queue popped past its tail");

	a_removed_head: assert property (@(posedge clk) disable iff (!arst_n)
		removed_q == head_q)
		else $error("removed count out of step with queue head");

	a_result_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(m_axis_tvalid) |-> $past(state_q) == ST_DONE)
		else $error("result raised outside the done step");

endmodule

FILE: test/tsf_checker.sv
// Checker for the topological sort feasibility block: watches the channels, predicts, compares.
module tsf_checker
	import tsf_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               cfg_we,
	input  logic [CNT_W-1:0]   cfg_wdata,
	input  logic               s_axis_tvalid,
	input  logic               s_axis_tready,
	input  logic [TDATA_W-1:0] s_axis_tdata,   // [5:0] dependent_node, [11:6] prerequisite_node
	input  logic               s_axis_tuser,   // [0] edge_valid
	input  logic               s_axis_tlast,
	input  logic               m_axis_tvalid,
	input  logic               m_axis_tready,
	input  logic [TDATA_W-1:0] m_axis_tdata,   // [0] feasible, [7:1] ordered_count, [8] bad_edge
	output int                 fail_count,
	output int                 pending
);
	timeunit 1ns;
	timeprecision 1ps;

	typedef struct packed {
		logic             feasible;
		logic [CNT_W-1:0] ordered;
		logic             bad;
	} verdict_t;

	// Shadow copy of the graph stores and the node count register
	logic [CNT_W-1:0]     count_shadow;
	logic [MAX_NODES-1:0] succ_rows [MAX_NODES];   // row per prerequisite, bit per dependent
	logic [CNT_W-1:0]     indeg [MAX_NODES];
	logic                 bad_seen;
	verdict_t             verdict_q [$];
	verdict_t             want;
	verdict_t             got;

	function automatic int nodes_in_use();
		return (count_shadow > CNT_W'(MAX_NODES)) ? MAX_NODES : int'(count_shadow);
	endfunction

	function automatic void clear_graph();
		for (int i = 0; i < MAX_NODES; i++) begin
			succ_rows[i] = '0;
			indeg[i]     = '0;
		end
		bad_seen = 1'b0;
	endfunction

	// Store one edge, or flag it when it names a node outside the graph
	function automatic void absorb_edge(input logic [NODE_W-1:0] dep,
			input logic [NODE_W-1:0] pre);
		int n;
		n = nodes_in_use();
		if (int'(dep) >= n || int'(pre) >= n) begin
			bad_seen = 1'b1;
		end else if (!succ_rows[pre][dep]) begin
			succ_rows[pre][dep] = 1'b1;
			if (indeg[dep] != DEG_MAX)
				indeg[dep] = indeg[dep] + CNT_W'(1);
		end
	endfunction

	// Kahn walk over the stored edges, then the verdict for the whole list
	function automatic verdict_t solve_graph();
		int n;
		int cur;
		int removed;
		int ready [$];
		logic [MAX_NODES-1:0] keep;
		verdict_t v;
		n = nodes_in_use();
		keep = '0;
		for (int k = 0; k < n; k++)
			keep[k] = 1'b1;
		// Flag stored edges that fall outside a lowered count
		for (int i = 0; i < MAX_NODES; i++) begin
			if (i >= n) begin
				if (succ_rows[i] != '0)
					bad_seen = 1'b1;
			end else if ((succ_rows[i] & ~keep) != '0) begin
				bad_seen = 1'b1;
			end
		end
		for (int i = 0; i < n; i++)
			if (indeg[i] == '0)
				ready.push_back(i);
		removed = 0;
		while (ready.size() > 0) begin
			cur = ready.pop_front();
			removed++;
			for (int j = 0; j < n; j++) begin
				if (succ_rows[cur][j] && indeg[j] != '0) begin
					indeg[j] = indeg[j] - CNT_W'(1);
					if (indeg[j] == '0)
						ready.push_back(j);
				end
			end
		end
		v.feasible = !bad_seen && (removed == n);
		v.ordered  = CNT_W'(removed);
		v.bad      = bad_seen;
		return v;
	endfunction

	// Follow writes and items, predict on each last item, compare each result
	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_shadow = NODES_MAX;
			clear_graph();
			verdict_q.delete();
			fail_count = 0;
			pending    = 0;
		end else begin
			if (cfg_we)
				count_shadow = cfg_wdata;
			if (s_axis_tvalid && s_axis_tready) begin
				if (s_axis_tuser)
					absorb_edge(s_axis_tdata[5:0], s_axis_tdata[11:6]);
				if (s_axis_tlast) begin
					verdict_q.push_back(solve_graph());
					clear_graph();
				end
			end
			if (m_axis_tvalid && m_axis_tready) begin
				got.feasible = m_axis_tdata[0];
				got.ordered  = m_axis_tdata[7:1];
				got.bad      = m_axis_tdata[8];
				if (verdict_q.size() == 0) begin
					$display("%0t: result with none pending: feasible %0d ordered %0d bad %0d",
						$time, got.feasible, got.ordered, got.bad);
					fail_count++;
				end else begin
					want = verdict_q.pop_front();
					if (got.feasible !== want.feasible) begin
						$display("%0t: feasible expected %0d actual %0d",
							$time, want.feasible, got.feasible);
						fail_count++;
					end
					if (got.ordered !== want.ordered) begin
						$display("%0t: ordered_count expected %0d actual %0d",
							$time, want.ordered, got.ordered);
						fail_count++;
					end
					if (got.bad !== want.bad) begin
						$display("%0t: bad_edge expected %0d actual %0d",
							$time, want.bad, got.bad);
						fail_count++;
					end
				end
			end
			pending = verdict_q.size();
		end
	end

endmodule

FILE: test/testbench.sv
// Stimulus and verdict for the topological sort feasibility block.
module testbench;
	import tsf_pkg::*;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int RANDOM_ITEMS = 850;
	localparam int HOLD_CYCLES  = 3000;
	localparam int SETTLE       = 8;
	localparam int TAIL         = 40;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               cfg_we = 1'b0;
	logic [CNT_W-1:0]   cfg_wdata = '0;
	logic               s_axis_tvalid = 1'b0;
	logic               s_axis_tready;
	logic [TDATA_W-1:0] s_axis_tdata = '0;
	logic               s_axis_tuser = 1'b0;
	logic               s_axis_tlast = 1'b0;
	logic               m_axis_tvalid;
	logic               m_axis_tready = 1'b0;
	logic [TDATA_W-1:0] m_axis_tdata;
	int                 fail_count;
	int                 pending;

	bit  quiet    = 1'b0;   // no idling on either side while set
	bit  hold_req = 1'b0;
	int  hold_left = 0;
	int  items_sent = 0;
	int  count_now = MAX_NODES;

	topological_sort_feasibility dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata)
	);

	tsf_checker chk (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_we        (cfg_we),
		.cfg_wdata     (cfg_wdata),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.fail_count    (fail_count),
		.pending       (pending)
	);

	always begin
		#10 clk = 1'b1;
		#10 clk = 1'b0;
	end

	// Give up on a hung run
	initial begin
		#400_000_000;
		$display("FAILURE");
		$finish;
	end

	// Receiver: random stalls, plus one long hold-off on request
	initial begin
		forever begin
			@(negedge clk);
			if (hold_req) begin
				hold_req  = 1'b0;
				hold_left = HOLD_CYCLES;
			end
			if (hold_left > 0) begin
				m_axis_tready <= 1'b0;
				hold_left--;
			end else begin
				m_axis_tready <= quiet || ($urandom_range(0, 99) >= 9);
			end
		end
	end

	// Offer one item and hold it until accepted
	task automatic send_item(input logic [NODE_W-1:0] dep, input logic [NODE_W-1:0] pre,
			input logic valid, input logic last);
		@(negedge clk);
		while (!quiet && $urandom_range(0, 99) < 9) begin
			s_axis_tvalid <= 1'b0;
			@(negedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= TDATA_W'({pre, dep});
		s_axis_tuser  <= valid;
		s_axis_tlast  <= last;
		do @(posedge clk); while (!s_axis_tready);
		if (valid || last)
			items_sent++;
	endtask

	// Drop valid, wait for every pending result, then let the block finish any edge
	task automatic settle();
		@(negedge clk);
		s_axis_tvalid <= 1'b0;
		while (pending != 0)
			@(posedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_count(input int value);
		settle();
		cfg_we    <= 1'b1;
		cfg_wdata <= CNT_W'(value);
		@(negedge clk);
		cfg_we    <= 1'b0;
		count_now = value;
	endtask

	// One edge list: mostly acyclic edges over a shuffled order, with noise mixed in
	task automatic random_list(input int len);
		int n;
		int kind;
		int a;
		int b;
		int t;
		int perm [MAX_NODES];
		bit have_prev;
		logic [NODE_W-1:0] dep;
		logic [NODE_W-1:0] pre;
		logic [NODE_W-1:0] prev_dep;
		logic [NODE_W-1:0] prev_pre;
		logic valid;
		logic last;
		n = (count_now > MAX_NODES) ? MAX_NODES : count_now;
		for (int i = 0; i < MAX_NODES; i++)
			perm[i] = i;
		for (int i = n - 1; i > 0; i--) begin
			a = $urandom_range(0, i);
			t = perm[i];
			perm[i] = perm[a];
			perm[a] = t;
		end
		have_prev = 1'b0;
		prev_dep = '0;
		prev_pre = '0;
		for (int k = 0; k < len; k++) begin
			last  = (k == len - 1);
			kind  = $urandom_range(0, 99);
			valid = 1'b1;
			dep   = NODE_W'($urandom_range(0, 63));
			pre   = NODE_W'($urandom_range(0, 63));
			if (kind < 8 || (last && $urandom_range(0, 1) == 0)) begin
				valid = 1'b0;
			end else if (kind < 14 && have_prev) begin
				dep = prev_dep;
				pre = prev_pre;
			end else if (kind < 20) begin
				if (n > 0)
					dep = NODE_W'($urandom_range(0, n - 1));
				pre = dep;
			end else if (kind < 26 && n < MAX_NODES) begin
				if ($urandom_range(0, 1) == 0)
					dep = NODE_W'($urandom_range(n, 63));
				else
					pre = NODE_W'($urandom_range(n, 63));
			end else if (kind < 32 || n < 2) begin
				if (n > 0) begin
					dep = NODE_W'($urandom_range(0, n - 1));
					pre = NODE_W'($urandom_range(0, n - 1));
				end
			end else begin
				a = $urandom_range(0, n - 2);
				b = $urandom_range(a + 1, n - 1);
				dep = NODE_W'(perm[b]);
				pre = NODE_W'(perm[a]);
			end
			send_item(dep, pre, valid, last);
			if (valid) begin
				have_prev = 1'b1;
				prev_dep  = dep;
				prev_pre  = pre;
			end
		end
	endtask

	initial begin
		int r;
		int lists;
		int len;
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// Reset count: no edges orders all, then a two-node cycle at the far ends
		send_item(6'd0, 6'd0, 1'b0, 1'b1);
		send_item(6'd63, 6'd0, 1'b1, 1'b0);
		send_item(6'd0, 6'd63, 1'b1, 1'b1);
		// Count above the maximum saturates; self-loop on the top node
		write_count(127);
		send_item(6'd63, 6'd63, 1'b1, 1'b1);
		// Count of zero: any edge is bad, no edge is feasible
		write_count(0);
		send_item(6'd0, 6'd0, 1'b1, 1'b1);
		send_item(6'd0, 6'd0, 1'b0, 1'b1);
		// Single node with an out-of-range edge
		write_count(1);
		send_item(6'd1, 6'd0, 1'b1, 1'b1);
		// Chain with a repeated edge and an empty marker in the middle
		write_count(4);
		send_item(6'd1, 6'd0, 1'b1, 1'b0);
		send_item(6'd1, 6'd0, 1'b1, 1'b0);
		send_item(6'd2, 6'd1, 1'b1, 1'b0);
		send_item(6'd3, 6'd2, 1'b1, 1'b0);
		send_item(6'd9, 6'd5, 1'b0, 1'b0);
		send_item(6'd3, 6'd0, 1'b1, 1'b1);
		// Count lowered mid-list leaves a stored edge outside the graph
		write_count(8);
		send_item(6'd7, 6'd1, 1'b1, 1'b0);
		send_item(6'd2, 6'd1, 1'b1, 1'b0);
		write_count(4);
		send_item(6'd3, 6'd2, 1'b1, 1'b1);

		// Hold the receiver off while short lists keep coming, so the input stalls
		write_count(3);
		hold_req = 1'b1;
		for (int i = 0; i < 8; i++) begin
			send_item(6'd1, 6'd0, 1'b1, 1'b0);
			send_item(6'd2, 6'd1, 1'b1, 1'b1);
		end

		// Random phases: mostly small graphs, a few at and beyond the maximum
		items_sent = 0;
		while (items_sent < RANDOM_ITEMS) begin
			r = $urandom_range(0, 99);
			if (r < 55)
				write_count($urandom_range(2, 8));
			else if (r < 70)
				write_count($urandom_range(9, 20));
			else if (r < 78)
				write_count($urandom_range(21, 63));
			else if (r < 85)
				write_count(MAX_NODES);
			else if (r < 89)
				write_count($urandom_range(65, 126));
			else if (r < 93)
				write_count(1);
			else if (r < 96)
				write_count(0);
			else
				write_count(127);
			lists = (count_now >= MAX_NODES) ? $urandom_range(1, 2) : $urandom_range(3, 6);
			for (int i = 0; i < lists; i++) begin
				quiet = (items_sent >= 300 && items_sent < 450);
				len = (count_now >= MAX_NODES) ? $urandom_range(1, 40) : $urandom_range(1, 12);
				random_list(len);
			end
		end
		quiet = 1'b0;

		settle();
		repeat (TAIL) @(posedge clk);
		if (fail_count == 0)
			$display("SUCCESS");
		else
			$display("FAILURE");
		$finish;
	end

endmodule

FILE: files.f
design/tsf_pkg.sv
design/topological_sort_feasibility.sv
test/tsf_checker.sv
test/testbench.sv
